>>> src/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and codes for the longest composable prefix block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcp_pkg;

    // Item kinds
    localparam logic [1:0] KIND_WORD_SYM = 2'd0;
    localparam logic [1:0] KIND_WORD_LEN = 2'd1;
    localparam logic [1:0] KIND_SEQ_SYM  = 2'd2;
    localparam logic [1:0] KIND_NEW_SEQ  = 2'd3;

    // Register indexes
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam int CFG_W  = 9;
    localparam int OUT_W  = 20;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       entry;
        logic [3:0]       char_position;
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] word_length;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] prefix_length;
        logic             reachable_here;
        logic             saturated;
    } t_out_item;

    // Dictionary write request
    typedef struct packed {
        logic             sym_en;
        logic             len_en;
        logic [3:0]       lane;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
    } t_dict_wr;

endpackage

`default_nettype wire

>>> src/longest_composable_prefix.sv
// ----------------------------------------------------------------------------
// longest_composable_prefix
// Word-break tracker: longest prefix of a symbol stream that splits wholly
// into words of a loaded dictionary.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in_data) carries four
//   kinds of item: write one word symbol, set a word length, feed one
//   sequence symbol, start a new sequence. Only a sequence symbol gives a
//   result on the output channel (o_out_valid / i_out_ready, o_out_data).
//   The APB port holds entries_in_use at address 0; write it only while idle.
//   Dictionary and length items are written as they are taken, and the block
//   stays ready for the next item. A sequence symbol scans the dictionary
//   memory, one entry per cycle through its single read port, over the N
//   active entries; the next item is taken once the result has been loaded
//   into the output register. With a saturated position counter the symbol
//   is dropped and the result is loaded without a scan.
//   Reset clears the sequence state, the register and the handshakes; the
//   dictionary is left undefined until written and needs no clearing pass.
//   When the receiver stalls, the result waits in the output register;
//   loading items are still taken, and a sequence symbol stalls at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_composable_prefix #(
    parameter int NUM_ENTRIES  = 256,
    parameter int MAX_WORD_LEN = 10,
    parameter int POS_BITS     = 20
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire lcp_pkg::t_in_item     i_in_data,
    // Output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output lcp_pkg::t_out_item         o_out_data,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    localparam int SW    = lcp_pkg::SYM_W;
    localparam int ROW_W = MAX_WORD_LEN * SW;
    localparam int AW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW    = $clog2(NUM_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [lcp_pkg::CFG_W-1:0] r_entries;
    logic [CW-1:0]           r_active;
    logic [CW-1:0]           r_idx;
    logic                    r_pend;
    logic                    r_hit;
    logic                    r_sat_path;
    logic [ROW_W-1:0]        r_window;
    logic [MAX_WORD_LEN-1:0] r_reach;
    logic [POS_BITS-1:0]     r_count;
    logic [POS_BITS-1:0]     r_best;
    logic                    r_flag;

    logic                    w_in_xfer;
    logic                    w_out_free;
    logic                    w_cfg_wr;
    logic                    w_issue;
    logic                    w_row_hit;
    logic                    w_entry_ok;
    logic [CW-1:0]           w_active;
    logic [ROW_W+SW-1:0]     w_win_shift;
    logic [MAX_WORD_LEN:0]   w_reach_shift;
    logic [POS_BITS-1:0]     n_best;
    logic [31:0]             w_best_ext;
    lcp_pkg::t_dict_wr       w_wr;
    logic [ROW_W-1:0]        w_rd_syms;
    logic [lcp_pkg::LEN_W-1:0] w_rd_len;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == lcp_pkg::REG_ENTRIES_IN_USE)
                      ? {{(32-lcp_pkg::CFG_W){1'b0}}, r_entries} : 32'd0;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    // Register values above the dictionary size act as the full dictionary
    assign w_active   = (32'(r_entries) > NUM_ENTRIES) ? CW'(NUM_ENTRIES)
                                                       : CW'(r_entries);
    assign w_entry_ok = 32'(i_in_data.entry) < NUM_ENTRIES;

    // Dictionary writes straight from the accepted item; out-of-range ones drop
    always_comb begin
        w_wr.sym_en = w_in_xfer && (i_in_data.kind == lcp_pkg::KIND_WORD_SYM)
                   && w_entry_ok && (int'(i_in_data.char_position) < MAX_WORD_LEN);
        w_wr.len_en = w_in_xfer && (i_in_data.kind == lcp_pkg::KIND_WORD_LEN)
                   && w_entry_ok;
        w_wr.lane   = i_in_data.char_position;
        w_wr.sym    = i_in_data.symbol;
        w_wr.len    = i_in_data.word_length;
    end

    // One read issued per scan cycle while entries remain
    assign w_issue = (r_state == S_SCAN) && (r_idx < r_active);

    lcp_dict_mem #(
        .NUM_ENTRIES  (NUM_ENTRIES),
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .AW           (AW)
    ) u_dict (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_wr_addr (AW'(i_in_data.entry)),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_syms (w_rd_syms),
        .o_rd_len  (w_rd_len)
    );

    lcp_match #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .POS_BITS     (POS_BITS)
    ) u_match (
        .i_row_syms (w_rd_syms),
        .i_len      (w_rd_len),
        .i_window   (r_window),
        .i_reach    (r_reach),
        .i_count    (r_count),
        .o_hit      (w_row_hit)
    );

    // Newest symbol enters slot 0, the oldest falls off the end
    assign w_win_shift   = {r_window, i_in_data.symbol};
    // Reachability history moves up one position and takes the scan outcome
    assign w_reach_shift = {r_reach, r_hit};
    assign n_best        = r_hit ? r_count : r_best;
    assign w_best_ext    = 32'(n_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= '0;
            r_active    <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_sat_path  <= 1'b0;
            r_window    <= '0;
            r_reach     <= MAX_WORD_LEN'(1);
            r_count     <= '0;
            r_best      <= '0;
            r_flag      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == lcp_pkg::REG_ENTRIES_IN_USE)) begin
                r_entries <= pwdata[lcp_pkg::CFG_W-1:0];
            end

            // Load a finished result, else drop valid once it has been taken
            if ((r_state == S_DONE) && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && (i_in_data.kind == lcp_pkg::KIND_NEW_SEQ)) begin
                        r_window <= '0;
                        r_reach  <= MAX_WORD_LEN'(1);
                        r_count  <= '0;
                        r_best   <= '0;
                        r_flag   <= 1'b0;
                    end else if (w_in_xfer && (i_in_data.kind == lcp_pkg::KIND_SEQ_SYM)) begin
                        r_hit  <= 1'b0;
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        if (r_count == '1) begin
                            // Saturated: drop the symbol, report without a scan
                            r_flag     <= 1'b1;
                            r_sat_path <= 1'b1;
                            r_state    <= S_DONE;
                        end else begin
                            r_window   <= w_win_shift[ROW_W-1:0];
                            r_count    <= r_count + 1'b1;
                            r_active   <= w_active;
                            r_sat_path <= 1'b0;
                            r_state    <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (w_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_pend <= w_issue;
                    if (r_pend && w_row_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (!w_issue && !r_pend) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        if (r_sat_path) begin
                            // no scan ran, so the held best length goes out
                            o_out_data.prefix_length  <= w_best_ext[lcp_pkg::OUT_W-1:0];
                            o_out_data.reachable_here <= 1'b0;
                            o_out_data.saturated      <= 1'b1;
                        end else begin
                            r_reach <= w_reach_shift[MAX_WORD_LEN-1:0];
                            r_best  <= n_best;
                            r_flag  <= r_flag || (r_count == '1);
                            o_out_data.prefix_length  <= w_best_ext[lcp_pkg::OUT_W-1:0];
                            o_out_data.reachable_here <= r_hit;
                            o_out_data.saturated      <= r_flag || (r_count == '1);
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/lcp_dict_mem.sv
// ----------------------------------------------------------------------------
// lcp_dict_mem
// Dictionary store: one row per entry holding the word symbols and length,
// symbol lanes written one at a time, one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_dict_mem #(
    parameter int NUM_ENTRIES  = 256,
    parameter int MAX_WORD_LEN = 10,
    parameter int AW           = 8
) (
    input  wire logic                                     i_clk,
    input  wire lcp_pkg::t_dict_wr                        i_wr,
    input  wire logic [AW-1:0]                            i_wr_addr,
    input  wire logic                                     i_rd_en,
    input  wire logic [AW-1:0]                            i_rd_addr,
    output logic      [MAX_WORD_LEN*lcp_pkg::SYM_W-1:0]   o_rd_syms,
    output logic      [lcp_pkg::LEN_W-1:0]                o_rd_len
);

    localparam int ROW_W = MAX_WORD_LEN * lcp_pkg::SYM_W;

    logic [ROW_W-1:0]          r_sym_mem [NUM_ENTRIES];
    logic [lcp_pkg::LEN_W-1:0] r_len_mem [NUM_ENTRIES];

    // Symbol store with per-lane write enables
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            if (i_wr.sym_en && (int'(i_wr.lane) == k)) begin
                r_sym_mem[i_wr_addr][k*lcp_pkg::SYM_W +: lcp_pkg::SYM_W] <= i_wr.sym;
            end
        end
        if (i_rd_en) begin
            o_rd_syms <= r_sym_mem[i_rd_addr];
        end
    end

    // Length store
    always_ff @(posedge i_clk) begin
        if (i_wr.len_en) begin
            r_len_mem[i_wr_addr] <= i_wr.len;
        end
        if (i_rd_en) begin
            o_rd_len <= r_len_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/lcp_match.sv
// ----------------------------------------------------------------------------
// lcp_match
// Compares one dictionary row against the symbol window and checks that the
// position where the word starts was reachable.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_match #(
    parameter int MAX_WORD_LEN = 10,
    parameter int POS_BITS     = 20
) (
    input  wire logic [MAX_WORD_LEN*lcp_pkg::SYM_W-1:0] i_row_syms,
    input  wire logic [lcp_pkg::LEN_W-1:0]              i_len,
    input  wire logic [MAX_WORD_LEN*lcp_pkg::SYM_W-1:0] i_window,
    input  wire logic [MAX_WORD_LEN-1:0]                i_reach,
    input  wire logic [POS_BITS-1:0]                    i_count,
    output logic                                        o_hit
);

    localparam int SW = lcp_pkg::SYM_W;

    logic w_fits;
    logic w_eq;

    // Word must not be longer than the sequence so far
    assign w_fits = {{(POS_BITS-lcp_pkg::LEN_W){1'b0}}, i_len} <= i_count;

    // Symbol i of the word lines up with window slot len-1-i
    always_comb begin
        o_hit = 1'b0;
        w_eq  = 1'b0;
        for (int l = 1; l <= MAX_WORD_LEN; l++) begin
            w_eq = 1'b1;
            for (int i = 0; i < l; i++) begin
                if (i_row_syms[i*SW +: SW] != i_window[(l-1-i)*SW +: SW]) begin
                    w_eq = 1'b0;
                end
            end
            if ((int'(i_len) == l) && w_eq && i_reach[l-1] && w_fits) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/lcp_checker.sv
// ----------------------------------------------------------------------------
// lcp_checker
// Port-level checks for the longest composable prefix block.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_port_checks (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire lcp_pkg::t_in_item  i_in_data,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire lcp_pkg::t_out_item o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic [31:0]        prdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // A sequence symbol is worked on alone
    a_seq_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.kind == lcp_pkg::KIND_SEQ_SYM)
        |=> !o_in_ready)
        else $error("item taken while a sequence symbol is in progress");

    // Loading and clearing items give no result
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid && o_in_ready
        && (i_in_data.kind != lcp_pkg::KIND_SEQ_SYM) |=> !o_out_valid)
        else $error("result produced by a non-sequence item");

    // Register read back after a write
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == lcp_pkg::REG_ENTRIES_IN_USE)
        |=> (paddr[2] != lcp_pkg::REG_ENTRIES_IN_USE)
            || (prdata[lcp_pkg::CFG_W-1:0] == $past(pwdata[lcp_pkg::CFG_W-1:0])))
        else $error("register read back differs from the value written");

endmodule

bind longest_composable_prefix lcp_port_checks u_lcp_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

`default_nettype wire
